// ===== design/scc_pkg.sv =====
// Shared types and constants of the sector cache clock replacement unit.
package scc_pkg;

  localparam int SECTOR_W = 32;
  localparam int INDEX_W  = 6;

  // Operation codes on the request channel
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // Classified request kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_FLUSH
  } req_kind_t;

  typedef struct packed {
    req_kind_t             kind;
    logic [SECTOR_W-1:0]   sector;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]    entry_index;
    logic                  hit;
    logic                  fill_needed;
    logic                  writeback_valid;
    logic [SECTOR_W-1:0]   writeback_sector;
    logic                  last;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_LOOK_WAIT,
    ST_SWEEP_HI,
    ST_SWEEP_HI_WAIT,
    ST_SWEEP_ALL_WAIT,
    ST_VICTIM,
    ST_FILL,
    ST_HIT,
    ST_FL_START,
    ST_FL_WAIT,
    ST_FL_READ,
    ST_FL_EMIT,
    ST_FL_LAST
  } eng_state_t;

endpackage

// ===== design/scc_fifo.sv =====
// Small register queue, used between front and back and on the result side.
module scc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);
  assign rd_data = slots[rd_ptr[AW-1:0]];

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) slots[wr_ptr[AW-1:0]] <= wr_data;
  end

endmodule

// ===== design/scc_front.sv =====
// Front end: takes requests, classifies the operation and queues them for the back end.
module scc_front
  import scc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [SECTOR_W-1:0] sector,
  output logic                req_valid,
  input  logic                req_pop,
  output req_t                req
);

  req_t  cls;
  logic  keep;
  logic  q_empty;
  logic [$bits(req_t)-1:0] q_out;

  // classify; the unused code is taken and dropped
  always_comb begin
    cls.sector = sector;
    cls.kind   = KIND_READ;
    keep       = 1'b1;
    case (operation)
      OP_READ:  cls.kind = KIND_READ;
      OP_WRITE: cls.kind = KIND_WRITE;
      OP_FLUSH: cls.kind = KIND_FLUSH;
      default:  keep     = 1'b0;
    endcase
  end

  scc_fifo #(
    .WIDTH ($bits(req_t)),
    .DEPTH (DEPTH)
  ) u_req_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && keep),
    .wr_data (cls),
    .rd_en   (req_pop),
    .rd_data (q_out),
    .empty   (q_empty),
    .full    (full)
  );

  assign req_valid = !q_empty;
  assign req       = req_t'(q_out);

endmodule

// ===== design/scc_find_first.sv =====
// Two-stage registered find-first-set over the entry vector (groups of 16, then groups).
module scc_find_first #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ENTRIES-1:0]         vec,
  output logic                       done,
  output logic                       found,
  output logic [$clog2(ENTRIES)-1:0] idx
);

  localparam int GRP   = 16;
  localparam int LW    = 4;
  localparam int NGRP  = (ENTRIES + GRP - 1) / GRP;
  localparam int PAD   = NGRP * GRP;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int IDX_W = $clog2(ENTRIES);

  logic [PAD-1:0]  pad_vec;
  logic [NGRP-1:0] g_any;
  logic [LW-1:0]   g_loc [NGRP];
  logic            s1_valid;
  logic [NGRP-1:0] s1_any;
  logic [LW-1:0]   s1_loc [NGRP];
  logic [GW-1:0]   sel;
  logic [GW+LW-1:0] full_idx;

  assign pad_vec = PAD'(vec);

  // stage 1: lowest set bit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      g_any[g] = |pad_vec[g*GRP +: GRP];
      g_loc[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (pad_vec[g*GRP + j]) g_loc[g] = LW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_any <= g_any;
    for (int g = 0; g < NGRP; g++) s1_loc[g] <= g_loc[g];
  end

  // stage 2: lowest group with a hit
  always_comb begin
    sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (s1_any[g]) sel = GW'(g);
    end
    full_idx = {sel, s1_loc[sel]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    found <= |s1_any;
    idx   <= IDX_W'(full_idx);
  end

endmodule

// ===== design/scc_engine.sv =====
// Back end: tag lookup, clock sweep, victim fill and flush sequencing.
module scc_engine
  import scc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_pop,
  input  req_t req,
  output logic res_push,
  input  logic res_full,
  output res_t res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  eng_state_t state, state_next;

  // per-entry state
  logic [SECTOR_W-1:0] tag [ENTRIES];
  logic [SECTOR_W-1:0] sec_mem [ENTRIES];
  logic [ENTRIES-1:0]  used;
  logic [ENTRIES-1:0]  dirty;
  logic [ENTRIES-1:0]  refb;
  logic [IDX_W-1:0]    hand;

  // current request
  req_kind_t           cur_kind;
  logic [SECTOR_W-1:0] cur_sector;
  logic [IDX_W-1:0]    cur_idx;
  logic                wrap_all;
  logic [SECTOR_W-1:0] rd_data;

  // pending flush result
  logic                held_valid;
  logic [IDX_W-1:0]    held_idx;
  logic [SECTOR_W-1:0] held_sector;

  // lane vectors
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] cand_vec;
  logic [ENTRIES-1:0] ge_hand;
  logic [ENTRIES-1:0] clr_range;

  // find-first unit
  logic               ff_start;
  logic [ENTRIES-1:0] ff_vec;
  logic               ff_done;
  logic               ff_found;
  logic [IDX_W-1:0]   ff_idx;

  // sequencer controls
  logic load_req, load_ff, load_hand, do_fill, do_hit, fl_clear, held_load, held_clear;
  logic is_write;
  logic [IDX_W-1:0] hand_next;

  assign is_write  = (cur_kind == KIND_WRITE);
  assign hand_next = (cur_idx == LAST_IDX) ? '0 : cur_idx + 1'b1;

  // per-entry compares
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = used[i] && (tag[i] == cur_sector);
      cand_vec[i]  = !used[i] || !refb[i];
      ge_hand[i]   = (IDX_W'(i) >= hand);
      if (wrap_all) begin
        clr_range[i] = 1'b1;
      end else if (hand <= cur_idx) begin
        clr_range[i] = (IDX_W'(i) >= hand) && (IDX_W'(i) <= cur_idx);
      end else begin
        clr_range[i] = (IDX_W'(i) >= hand) || (IDX_W'(i) <= cur_idx);
      end
    end
  end

  scc_find_first #(.ENTRIES(ENTRIES)) u_ff (
    .clk   (clk),
    .rst   (rst),
    .start (ff_start),
    .vec   (ff_vec),
    .done  (ff_done),
    .found (ff_found),
    .idx   (ff_idx)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    req_pop    = 1'b0;
    ff_start   = 1'b0;
    ff_vec     = match_vec;
    res_push   = 1'b0;
    res        = '0;
    load_req   = 1'b0;
    load_ff    = 1'b0;
    load_hand  = 1'b0;
    do_fill    = 1'b0;
    do_hit     = 1'b0;
    fl_clear   = 1'b0;
    held_load  = 1'b0;
    held_clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          req_pop  = 1'b1;
          load_req = 1'b1;
          state_next = (req.kind == KIND_FLUSH) ? ST_FL_START : ST_LOOK;
        end
      end
      ST_LOOK: begin
        ff_start   = 1'b1;
        ff_vec     = match_vec;
        state_next = ST_LOOK_WAIT;
      end
      ST_LOOK_WAIT: begin
        if (ff_done) begin
          if (ff_found) begin
            load_ff    = 1'b1;
            state_next = ST_HIT;
          end else begin
            state_next = ST_SWEEP_HI;
          end
        end
      end
      ST_SWEEP_HI: begin
        ff_start   = 1'b1;
        ff_vec     = cand_vec & ge_hand;
        state_next = ST_SWEEP_HI_WAIT;
      end
      ST_SWEEP_HI_WAIT: begin
        if (ff_done) begin
          if (ff_found) begin
            load_ff    = 1'b1;
            state_next = ST_VICTIM;
          end else begin
            // nothing from the hand up: search from entry zero
            ff_start   = 1'b1;
            ff_vec     = cand_vec;
            state_next = ST_SWEEP_ALL_WAIT;
          end
        end
      end
      ST_SWEEP_ALL_WAIT: begin
        if (ff_done) begin
          if (ff_found) begin
            load_ff = 1'b1;
          end else begin
            // every entry used and referenced: full turn, victim is the hand
            load_hand = 1'b1;
          end
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        state_next = ST_FILL;
      end
      ST_FILL: begin
        res.entry_index      = INDEX_W'(cur_idx);
        res.fill_needed      = 1'b1;
        res.writeback_valid  = dirty[cur_idx];
        res.writeback_sector = dirty[cur_idx] ? rd_data : '0;
        res.last             = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          do_fill    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_HIT: begin
        res.entry_index = INDEX_W'(cur_idx);
        res.hit         = 1'b1;
        res.last        = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          do_hit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FL_START: begin
        ff_start   = 1'b1;
        ff_vec     = dirty;
        state_next = ST_FL_WAIT;
      end
      ST_FL_WAIT: begin
        if (ff_done) begin
          if (ff_found) begin
            load_ff    = 1'b1;
            fl_clear   = 1'b1;
            state_next = ST_FL_READ;
          end else begin
            state_next = ST_FL_LAST;
          end
        end
      end
      ST_FL_READ: begin
        state_next = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        // previous dirty entry goes out once the next one is known
        res.entry_index      = INDEX_W'(held_idx);
        res.writeback_valid  = 1'b1;
        res.writeback_sector = held_sector;
        if (!held_valid) begin
          held_load  = 1'b1;
          state_next = ST_FL_START;
        end else if (!res_full) begin
          res_push   = 1'b1;
          held_load  = 1'b1;
          state_next = ST_FL_START;
        end
      end
      ST_FL_LAST: begin
        res.last = 1'b1;
        if (held_valid) begin
          res.entry_index      = INDEX_W'(held_idx);
          res.writeback_valid  = 1'b1;
          res.writeback_sector = held_sector;
        end
        if (!res_full) begin
          res_push   = 1'b1;
          held_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // entry control bits, hand and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      dirty      <= '0;
      refb       <= '0;
      hand       <= '0;
      held_valid <= 1'b0;
    end else begin
      if (do_fill) begin
        used[cur_idx]  <= 1'b1;
        dirty[cur_idx] <= is_write;
        for (int i = 0; i < ENTRIES; i++) begin
          if (clr_range[i]) refb[i] <= 1'b0;
        end
        refb[cur_idx] <= 1'b1;
        hand          <= hand_next;
      end
      if (do_hit) begin
        refb[cur_idx] <= 1'b1;
        if (is_write) dirty[cur_idx] <= 1'b1;
      end
      if (fl_clear) dirty[ff_idx] <= 1'b0;
      if (held_load) begin
        held_valid <= 1'b1;
      end else if (held_clear) begin
        held_valid <= 1'b0;
      end
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (load_req) begin
      cur_kind   <= req.kind;
      cur_sector <= req.sector;
    end
    if (load_ff) begin
      cur_idx  <= ff_idx;
      wrap_all <= 1'b0;
    end else if (load_hand) begin
      cur_idx  <= hand;
      wrap_all <= 1'b1;
    end
    if (held_load) begin
      held_idx    <= cur_idx;
      held_sector <= rd_data;
    end
    if (do_fill) tag[cur_idx] <= cur_sector;
  end

  // sector store, read by entry index with registered data
  always_ff @(posedge clk) begin
    if (do_fill) sec_mem[cur_idx] <= cur_sector;
    rd_data <= sec_mem[cur_idx];
  end

endmodule

// ===== design/sector_cache_clock_replacement_unit.sv =====
// Top level of the sector cache clock replacement unit: front, back and result queue.
//
// Tag and policy engine of a fully associative disk sector cache with clock
// (second-chance) replacement. Requests enter through push/full and carry an
// operation (read, write, flush all) and a sector number; the unused code is
// taken and dropped. Results leave through empty/pop, oldest first; each
// carries the entry index, hit, fill and writeback flags and a last marker.
// A read or write gives one result, set on a hit by the lookup pass and on
// a miss by the lookup pass and one or two sweep passes of the registered
// find-first unit over the entry bits. A flush gives one result per dirty
// entry, each set by one find-first pass and one sector-store read; with no
// dirty entry it gives a single last result.
// Two-entry queues sit on the request and result sides, so requests are
// still taken while results wait; when the receiver stops popping, the back
// end holds its result and the request queue fills until full rises.
// Reset empties both queues, marks every entry unused and puts the hand at
// entry zero; no clearing pass is needed.
module sector_cache_clock_replacement_unit
  import scc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [SECTOR_W-1:0] sector,
  output logic                empty,
  input  logic                pop,
  output logic [INDEX_W-1:0]  entry_index,
  output logic                hit,
  output logic                fill_needed,
  output logic                writeback_valid,
  output logic [SECTOR_W-1:0] writeback_sector,
  output logic                last
);

  localparam int QDEPTH = 2;

  logic req_valid;
  logic req_pop;
  req_t req;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;
  logic [$bits(res_t)-1:0] res_q_out;

  scc_front #(.DEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .sector    (sector),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .req       (req)
  );

  scc_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_pop   (req_pop),
    .req       (req),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res_in)
  );

  scc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_q_out),
    .empty   (empty),
    .full    (res_full)
  );

  assign res_out          = res_t'(res_q_out);
  assign entry_index      = res_out.entry_index;
  assign hit              = res_out.hit;
  assign fill_needed      = res_out.fill_needed;
  assign writeback_valid  = res_out.writeback_valid;
  assign writeback_sector = res_out.writeback_sector;
  assign last             = res_out.last;

  // back end never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // a hit never asks for a fill or a writeback
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && hit) |-> (!fill_needed && !writeback_valid && last))
    else $error("hit result with fill or writeback");

  // writeback sector reads zero unless a writeback is flagged
  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !writeback_valid) |-> (writeback_sector == '0))
    else $error("writeback sector set without writeback");

  // a fill always closes its request
  a_fill_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && fill_needed) |-> (last && !hit))
    else $error("fill result not final");

endmodule
